// ----- hw/rtl/text_console_char_writer_top_macros.svh -----
// ----------------------------------------------------------------------------
// text console char writer assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define TCCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// shared constants and types of the text console char writer
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int ROWS_DEF     = 25;
    localparam int MAX_COLS_DEF = 128;

    // widest cell address over the parameter range (64 rows x 256 cols)
    localparam int MEM_AW_MAX = 14;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0] COLS_RESET = 8'd80;

    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] ATTR_TEXT = 8'h0f;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } item_t;

    // packed so that the lowest field sits in the lowest bits
    typedef struct packed {
        logic [7:0] cell_attr;
        logic [7:0] cell_char;
        logic       scrolled;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
    } res_t;

    localparam int RES_W = $bits(res_t);

    typedef struct packed {
        logic                  we;
        logic [MEM_AW_MAX-1:0] waddr;
        logic [15:0]           wdata;
        logic                  re;
        logic [MEM_AW_MAX-1:0] raddr;
    } mem_req_t;

endpackage

// ----- hw/rtl/tccw_screen_mem.sv -----
// ----------------------------------------------------------------------------
// tccw_screen_mem
// screen cell store, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module tccw_screen_mem #(
    parameter int DEPTH = tccw_pkg::ROWS_DEF * tccw_pkg::MAX_COLS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  tccw_pkg::mem_req_t req,
    output logic [15:0]        rdata
);

    logic [15:0] cells [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            cells[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= cells[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tccw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tccw_ctrl
// cursor logic and store sequencer: put, read, scroll and clearing sweep
// ----------------------------------------------------------------------------
module tccw_ctrl #(
    parameter int ROWS     = tccw_pkg::ROWS_DEF,
    parameter int MAX_COLS = tccw_pkg::MAX_COLS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               item_valid,
    output logic               item_ready,
    input  tccw_pkg::item_t    item,
    output logic               res_valid,
    input  logic               res_ready,
    output tccw_pkg::res_t     res,
    output tccw_pkg::mem_req_t mem_req,
    input  logic [15:0]        mem_rdata
);

    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int AW     = RW + CW;
    localparam int STRIDE = 1 << CW;
    localparam int DEPTH  = ROWS * STRIDE;
    localparam int MW     = tccw_pkg::MEM_AW_MAX;

    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_STEP   = AW'(STRIDE);
    localparam logic [AW-1:0] BOTTOM_ROW = AW'((ROWS - 1) * STRIDE);
    localparam logic [8:0]    NCOLS_MAX  = 9'(MAX_COLS);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_RDWAIT = 8'b0000_1000,
        S_SCROLL = 8'b0001_0000,
        S_DRAIN  = 8'b0010_0000,
        S_WIPE   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [7:0]      cc_reg;
    logic [RW-1:0]   cur_row_reg;
    logic [CW-1:0]   cur_col_reg;
    tccw_pkg::item_t item_reg;
    logic [AW-1:0]   scan_reg;
    logic [1:0]      scnt_reg;
    logic            dval_reg;
    logic [AW-1:0]   daddr_reg;
    logic            scrolled_reg;
    logic [7:0]      cchar_reg;
    logic [7:0]      cattr_reg;

    logic [8:0]      ncols;
    logic [RW+1:0]   row_a;
    logic [CW:0]     col_a;
    logic            printable;
    logic [1:0]      scnt;
    logic [RW-1:0]   row_fin;
    logic [CW-1:0]   col_fin;
    logic            rd_ok;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   cur_addr;

    // clamp the column register to 1..MAX_COLS
    always_comb begin
        if (cc_reg == 8'd0) begin
            ncols = 9'd1;
        end else if ({1'b0, cc_reg} > NCOLS_MAX) begin
            ncols = NCOLS_MAX;
        end else begin
            ncols = {1'b0, cc_reg};
        end
    end

    // cursor motion for a put
    always_comb begin
        row_a     = {2'b00, cur_row_reg};
        col_a     = {1'b0, cur_col_reg};
        printable = 1'b0;
        unique case (item_reg.char_code)
            tccw_pkg::CH_LF: begin
                row_a = row_a + (RW+2)'(1);
            end
            tccw_pkg::CH_CR: begin
                col_a = '0;
            end
            tccw_pkg::CH_FF: begin
                row_a = '0;
                col_a = '0;
            end
            default: begin
                printable = 1'b1;
                col_a     = col_a + (CW+1)'(1);
            end
        endcase
        if (9'(col_a) >= ncols) begin
            row_a = row_a + (RW+2)'(1);
            col_a = '0;
        end
        // line feed plus wrap can pass the last row by two
        if (row_a >= (RW+2)'(ROWS)) begin
            scnt    = 2'(row_a - (RW+2)'(ROWS - 1));
            row_fin = RW'(ROWS - 1);
        end else begin
            scnt    = 2'd0;
            row_fin = RW'(row_a);
        end
        col_fin = CW'(col_a);
    end

    assign rd_ok    = (item_reg.read_row < ROWS) && (item_reg.read_col < MAX_COLS);
    assign rd_addr  = {RW'(item_reg.read_row), CW'(item_reg.read_col)};
    assign cur_addr = {cur_row_reg, cur_col_reg};

    // store port
    always_comb begin
        mem_req = '0;
        unique case (state_reg)
            S_INIT, S_WIPE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MW'(scan_reg);
            end
            S_EXEC: begin
                if (item_reg.kind == tccw_pkg::KIND_PUT) begin
                    mem_req.we    = printable;
                    mem_req.waddr = MW'(cur_addr);
                    mem_req.wdata = {tccw_pkg::ATTR_TEXT, item_reg.char_code};
                end else begin
                    mem_req.re    = rd_ok;
                    mem_req.raddr = MW'(rd_addr);
                end
            end
            S_SCROLL, S_DRAIN: begin
                // row copy: read one row down, write the cell fetched last cycle
                mem_req.re    = (state_reg == S_SCROLL);
                mem_req.raddr = MW'(scan_reg);
                mem_req.we    = dval_reg;
                mem_req.waddr = MW'(daddr_reg);
                mem_req.wdata = mem_rdata;
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                if (scan_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (item_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (item_reg.kind == tccw_pkg::KIND_READ) begin
                    state_next = rd_ok ? S_RDWAIT : S_DONE;
                end else begin
                    state_next = (scnt != 2'd0) ? S_SCROLL : S_DONE;
                end
            end
            S_RDWAIT: begin
                state_next = S_DONE;
            end
            S_SCROLL: begin
                if (scan_reg == LAST_ADDR) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_WIPE;
            end
            S_WIPE: begin
                if (scan_reg == LAST_ADDR) begin
                    state_next = (scnt_reg == 2'd1) ? S_DONE : S_SCROLL;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            cc_reg      <= tccw_pkg::COLS_RESET;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            scan_reg    <= '0;
            scnt_reg    <= '0;
            dval_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            dval_reg  <= (state_reg == S_SCROLL);
            if (cfg_we) begin
                cc_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_INIT, S_SCROLL: begin
                    scan_reg <= scan_reg + AW'(1);
                end
                S_EXEC: begin
                    if (item_reg.kind == tccw_pkg::KIND_PUT) begin
                        cur_row_reg <= row_fin;
                        cur_col_reg <= col_fin;
                        scnt_reg    <= scnt;
                        scan_reg    <= ROW_STEP;
                    end
                end
                S_DRAIN: begin
                    scan_reg <= BOTTOM_ROW;
                end
                S_WIPE: begin
                    if (scan_reg == LAST_ADDR) begin
                        scnt_reg <= scnt_reg - 2'd1;
                        scan_reg <= ROW_STEP;
                    end else begin
                        scan_reg <= scan_reg + AW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        daddr_reg <= scan_reg - ROW_STEP;
        if (state_reg == S_IDLE && item_valid) begin
            item_reg <= item;
        end
        if (state_reg == S_EXEC) begin
            cchar_reg    <= 8'd0;
            cattr_reg    <= 8'd0;
            scrolled_reg <= (item_reg.kind == tccw_pkg::KIND_PUT) && (scnt != 2'd0);
        end
        if (state_reg == S_RDWAIT) begin
            cchar_reg <= mem_rdata[7:0];
            cattr_reg <= mem_rdata[15:8];
        end
    end

    assign item_ready     = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_DONE);
    assign res.cursor_row = 5'(cur_row_reg);
    assign res.cursor_col = 7'(cur_col_reg);
    assign res.scrolled   = scrolled_reg;
    assign res.cell_char  = cchar_reg;
    assign res.cell_attr  = cattr_reg;

endmodule

// ----- hw/rtl/text_console_char_writer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// teletype-style text console writer over a character/attribute cell store
// ----------------------------------------------------------------------------
// A put beat handles one byte at the cursor: line feed moves down a row,
// carriage return goes to column 0, form feed homes the cursor, and any other
// byte is stored with attribute 0x0f and advances the column, wrapping at the
// programmed column count; running off the bottom scrolls the store up a row
// and blanks the new bottom row. A read beat returns one cell for display
// scanning. Every beat gives one result beat carrying the cursor after it.
// Sequencing: a put passes an execute and a done state before the next accept;
// a read adds a wait on the store's registered read data, skipped for a cell
// outside the store. Done holds until the output register can take the result,
// and the single sequencer takes one beat at a time. Each row scrolled makes
// the sequencer copy every row but the top up a row, one cell a cycle through
// the store's single read and write port, and then blank the bottom row. After
// reset the store is cleared in one pass over every cell with s_tready low;
// column_count writes are taken at any time. A finished result waits in
// the output register while the next beat is accepted.
// ----------------------------------------------------------------------------
module text_console_char_writer_top #(
    parameter int ROWS     = tccw_pkg::ROWS_DEF,
    parameter int MAX_COLS = tccw_pkg::MAX_COLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // column count register
    input  logic                           cfg_we,
    input  logic [7:0]                     cfg_wdata,
    // input beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tccw_pkg::S_TDATA_W-1:0] s_tdata,  // char_code, read_row, read_col
    input  logic                           s_tuser,  // kind
    // result beats
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cursor_row, cursor_col, scrolled, cell_char, cell_attr
    output logic [tccw_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH = ROWS * (1 << $clog2(MAX_COLS));
    localparam int AW    = $clog2(ROWS) + $clog2(MAX_COLS);

    tccw_pkg::item_t    item;
    tccw_pkg::res_t     res;
    tccw_pkg::mem_req_t mem_req;
    logic [15:0]        mem_rdata;
    logic               item_ready;
    logic               res_valid;
    logic               res_ready;

    logic                           m_tvalid_reg;
    logic [tccw_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // unpack the input beat
    assign item.kind      = s_tuser;
    assign item.char_code = s_tdata[7:0];
    assign item.read_row  = s_tdata[12:8];
    assign item.read_col  = s_tdata[19:13];

    assign s_tready = item_ready;

    tccw_ctrl #(
        .ROWS     (ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (s_tvalid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    tccw_screen_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // output register: a result can load when the slot is empty or draining
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {(tccw_pkg::M_TDATA_W - tccw_pkg::RES_W)'(0), res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/tccw_checker.sv -----
// ----------------------------------------------------------------------------
// tccw_checker
// port-level checks of the text console char writer result channel
// ----------------------------------------------------------------------------
`include "text_console_char_writer_top_macros.svh"

module tccw_checker #(
    parameter int ROWS = tccw_pkg::ROWS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tccw_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result beat holds
    `TCCW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // a scroll only comes from a put, which reports an empty cell
    `TCCW_ASSERT_NOW(a_scroll_no_cell, m_tvalid && m_tdata[12], m_tdata[28:13] == 16'h0000, "scrolled beat carries cell data")

    // after a scroll the cursor sits on the last row
    `TCCW_ASSERT_NOW(a_scroll_bottom, m_tvalid && m_tdata[12], (ROWS > 32) || (m_tdata[4:0] == 5'(ROWS - 1)), "cursor not on last row after scroll")

    // cursor row stays inside the screen
    `TCCW_ASSERT_NOW(a_row_range, m_tvalid, (ROWS > 32) || (m_tdata[4:0] < ROWS), "cursor row beyond last row")

endmodule

bind text_console_char_writer_top tccw_checker #(
    .ROWS (ROWS)
) u_tccw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/text_console_char_writer_top_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer_top_tb
// self-checking bench for the teletype text console writer
// ----------------------------------------------------------------------------
// A shadow of the cursor and the cell store predicts the result of every
// beat the block takes in. Result beats are checked field by field against
// the oldest prediction. A directed opening covers reads in and out of
// range, the control bytes, the byte extremes, single and double scrolls,
// and writes past a lowered column count. Random phases with several column
// counts follow, mostly text lines and scan reads. Idling on both sides,
// a long output stall and a full drain are mixed in.
// ----------------------------------------------------------------------------
module text_console_char_writer_top_tb;

    localparam int N_ROWS        = tccw_pkg::ROWS_DEF;
    localparam int N_COLS        = tccw_pkg::MAX_COLS_DEF;
    localparam int QUIET_LIMIT   = 40000;  // two scroll walks plus stalls, many times over
    localparam int HOLD_CYCLES   = 400;    // long output stall
    localparam int SCROLL_BUDGET = 25;     // rows scrolled per random phase
    localparam int PHASE_ITEMS   = 225;

    // shadow of the console: cursor, column register and cell store
    class console_shadow;
        logic [15:0] store [N_ROWS*N_COLS];  // attr high, char low
        int unsigned cur_row;
        int unsigned cur_col;
        int unsigned col_reg;
        int unsigned rows_scrolled;
        int unsigned mismatches;
        tccw_pkg::res_t pending_results [$];

        function new();
            foreach (store[i]) store[i] = '0;
            cur_row       = 0;
            cur_col       = 0;
            col_reg       = tccw_pkg::COLS_RESET;
            rows_scrolled = 0;
            mismatches    = 0;
        endfunction

        function int unsigned cols_in_use();
            if (col_reg == 0) return 1;
            if (col_reg > N_COLS) return N_COLS;
            return col_reg;
        endfunction

        function void set_columns(logic [7:0] value);
            col_reg = value;
        endfunction

        // predict the result of one accepted input beat
        function void note_item(tccw_pkg::item_t it);
            tccw_pkg::res_t want;
            int unsigned    row;
            int unsigned    col;
            int unsigned    ncols;
            want = '0;
            if (it.kind == tccw_pkg::KIND_READ) begin
                if (it.read_row < N_ROWS) begin
                    want.cell_char = store[it.read_row*N_COLS + it.read_col][7:0];
                    want.cell_attr = store[it.read_row*N_COLS + it.read_col][15:8];
                end
            end else begin
                ncols = cols_in_use();
                row   = cur_row;
                col   = cur_col;
                if (it.char_code == tccw_pkg::CH_LF) begin
                    row++;
                end else if (it.char_code == tccw_pkg::CH_CR) begin
                    col = 0;
                end else if (it.char_code == tccw_pkg::CH_FF) begin
                    row = 0;
                    col = 0;
                end else begin
                    if (row < N_ROWS && col < N_COLS)
                        store[row*N_COLS + col] = {tccw_pkg::ATTR_TEXT, it.char_code};
                    col++;
                end
                if (col >= ncols) begin
                    row++;
                    col = 0;
                end
                // one whole-row shift per row passed
                while (row >= N_ROWS) begin
                    for (int i = 0; i < (N_ROWS-1)*N_COLS; i++)
                        store[i] = store[i + N_COLS];
                    for (int i = (N_ROWS-1)*N_COLS; i < N_ROWS*N_COLS; i++)
                        store[i] = '0;
                    row--;
                    want.scrolled = 1'b1;
                    rows_scrolled++;
                end
                cur_row = row;
                cur_col = col;
            end
            want.cursor_row = cur_row[4:0];
            want.cursor_col = cur_col[6:0];
            pending_results.push_back(want);
        endfunction

        function void check_beat(logic [tccw_pkg::M_TDATA_W-1:0] beat);
            tccw_pkg::res_t got;
            tccw_pkg::res_t want;
            got = tccw_pkg::res_t'(beat[tccw_pkg::RES_W-1:0]);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %h", beat);
                return;
            end
            want = pending_results.pop_front();
            if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
                got.scrolled !== want.scrolled || got.cell_char !== want.cell_char ||
                got.cell_attr !== want.cell_attr) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: row %0d/%0d col %0d/%0d scrolled %0d/%0d",
                             want.cursor_row, got.cursor_row, want.cursor_col,
                             got.cursor_col, want.scrolled, got.scrolled,
                             " char %h/%h attr %h/%h (expected/actual)",
                             want.cell_char, got.cell_char, want.cell_attr,
                             got.cell_attr);
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [7:0]                     cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [tccw_pkg::S_TDATA_W-1:0] s_tdata;   // char_code, read_row, read_col
    logic                           s_tuser;   // kind
    logic                           m_tvalid;
    logic                           m_tready;
    // cursor_row, cursor_col, scrolled, cell_char, cell_attr
    logic [tccw_pkg::M_TDATA_W-1:0] m_tdata;

    console_shadow sb = new();

    int              snd_idle_pct;
    int              rcv_idle_pct;
    bit              hold_req;
    bit              guard_scroll;       // steer the cursor home at the bottom row
    int unsigned     phase_scroll_base;
    int unsigned     quiet_cycles;
    tccw_pkg::item_t in_beat;

    text_console_char_writer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 10 unit clock period
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // monitor: check the result beat first, then note the input beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata);
            if (s_tvalid && s_tready) begin
                in_beat.kind      = s_tuser;
                in_beat.char_code = s_tdata[7:0];
                in_beat.read_row  = s_tdata[12:8];
                in_beat.read_col  = s_tdata[19:13];
                sb.note_item(in_beat);
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready = !(rcv_idle_pct != 0 && $urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    // offer one beat, with random idle cycles in front, and wait for accept
    task automatic send_beat(input logic kind, input logic [7:0] code,
                             input logic [4:0] rrow, input logic [6:0] rcol);
        @(negedge aclk);
        while (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        // at the bottom row most puts become a form feed so scrolls stay rare
        if (guard_scroll && kind == tccw_pkg::KIND_PUT && sb.cur_row == N_ROWS - 1 &&
            (sb.rows_scrolled - phase_scroll_base >= SCROLL_BUDGET ||
             $urandom_range(0, 3) != 0))
            code = tccw_pkg::CH_FF;
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {4'b0, rcol, rrow, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic put_char(input logic [7:0] code);
        send_beat(tccw_pkg::KIND_PUT, code, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_at(input logic [4:0] row, input logic [6:0] col);
        send_beat(tccw_pkg::KIND_READ, 8'($urandom), row, col);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_columns(input logic [7:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        sb.set_columns(value);
    endtask

    // random traffic: text lines, scan reads, stray bytes and form feeds
    task automatic run_phase(input int n_items, input int hold_at, input int drain_at);
        int sent;
        int pick;
        int len;
        sent              = 0;
        phase_scroll_base = sb.rows_scrolled;
        while (sent < n_items) begin
            if (hold_at >= 0 && sent >= hold_at) begin
                hold_req = 1'b1;
                hold_at  = -1;
            end
            if (drain_at >= 0 && sent >= drain_at) begin
                wait_drained();
                drain_at = -1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // one line of text, usually closed by carriage return and line feed
                len = $urandom_range(0, sb.cols_in_use() + 2);
                if (len > 48 && $urandom_range(0, 3) != 0)
                    len = $urandom_range(0, 48);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 7) == 0)
                        put_char(8'($urandom));
                    else
                        put_char(8'($urandom_range(8'h20, 8'h7e)));
                end
                if ($urandom_range(0, 9) != 0)
                    put_char(tccw_pkg::CH_CR);
                if ($urandom_range(0, 9) != 0)
                    put_char(tccw_pkg::CH_LF);
                sent += len + 2;
            end else if (pick < 75) begin
                // scan a few cells, mostly inside the screen
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 4) == 0)
                        read_at(5'($urandom), 7'($urandom));
                    else
                        read_at(5'($urandom_range(0, N_ROWS - 1)),
                                7'($urandom_range(0, $urandom_range(0, 1) ? 15 : 127)));
                end
                sent += len;
            end else if (pick < 90) begin
                put_char(8'($urandom));
                sent++;
            end else if (pick < 95) begin
                put_char(tccw_pkg::CH_FF);
                sent++;
            end else begin
                read_at(5'($urandom), 7'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        int col_plan [8];

        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = tccw_pkg::KIND_PUT;
        hold_req     = 1'b0;
        guard_scroll = 1'b0;
        quiet_cycles = 0;
        snd_idle_pct = 35;
        rcv_idle_pct = 49;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: cleared store, out-of-range row, byte extremes, controls
        read_at(5'd0, 7'd0);
        read_at(5'd31, 7'd127);
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hff);
        read_at(5'd0, 7'd0);
        read_at(5'd0, 7'd1);
        read_at(5'd0, 7'd2);
        put_char(tccw_pkg::CH_CR);
        put_char(tccw_pkg::CH_LF);
        put_char(tccw_pkg::CH_FF);
        put_char(8'h78);

        // walk to the bottom row, then one plain scroll
        for (int i = 0; i < N_ROWS; i++)
            put_char(tccw_pkg::CH_LF);
        read_at(5'd0, 7'd1);
        put_char(8'h61);
        put_char(8'h62);
        put_char(8'h63);

        // cursor past a lowered column count: line feed scrolls twice
        set_columns(8'd2);
        put_char(tccw_pkg::CH_LF);
        read_at(5'd22, 7'd2);

        // printable byte past the column count is still stored, then wraps
        set_columns(8'd80);
        put_char(8'h61);
        put_char(8'h62);
        put_char(8'h63);
        set_columns(8'd2);
        put_char(8'h5a);
        read_at(5'd23, 7'd3);

        // zero column count acts as one column
        set_columns(8'd0);
        put_char(8'h71);
        put_char(tccw_pkg::CH_FF);
        put_char(8'h71);
        read_at(5'd0, 7'd0);

        // register above the store width acts as the full width
        set_columns(8'd255);
        put_char(8'h72);
        put_char(8'h73);
        read_at(5'd24, 7'd127);

        // random phases over several column counts and idling patterns
        guard_scroll = 1'b1;
        col_plan     = '{1, 128, 0, 255, 40, 80, 0, 0};
        col_plan[6]  = $urandom_range(2, 127);
        col_plan[7]  = $urandom_range(0, 255);
        for (int p = 0; p < 8; p++) begin
            if (p < 3) begin
                snd_idle_pct = 35;
                rcv_idle_pct = 49;
            end else if (p < 6) begin
                snd_idle_pct = 49;
                rcv_idle_pct = 35;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            set_columns(8'(col_plan[p]));
            run_phase(PHASE_ITEMS, (p == 1) ? 100 : -1, (p == 4) ? 100 : -1);
        end

        // let the last results come back, then allow a little extra time
        wait_drained();
        repeat (50) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
